// File: rtl/core/bdpc_pkg.sv
// bdpc_pkg: shared types and constants for the button debounce press classifier
// no dependencies; used by bdpc_lane, bdpc_merge and the top level
package bdpc_pkg;

  // field widths
  localparam int TIME_W    = 32;
  localparam int LEVEL_W   = 4;
  localparam int CFG_W     = 16;
  localparam int BTN_IDX_W = 2;
  localparam int IN_DATA_W = 40;  // now_ms + button_levels, padded to bytes
  localparam int OUT_DATA_W = 8;  // button_index, padded to a byte
  localparam int CFG_IDX_W = 2;

  // most events one sample can produce
  localparam int MAX_EVENTS = 4;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1
  } cfg_idx_t;

  // event kinds
  localparam logic EV_SHORT = 1'b0;
  localparam logic EV_LONG  = 1'b1;

  // one lane's finding for the current word
  typedef struct packed {
    logic valid;
    logic kind;
  } lane_ev_t;

endpackage

// File: rtl/core/bdpc_lane.sv
// bdpc_lane: debounce and press timing state for one button
// depends on bdpc_pkg
module bdpc_lane
  import bdpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              raw_level,
  input  logic [CFG_W-1:0]  debounce_ms,
  input  logic [CFG_W-1:0]  long_press_ms,
  output lane_ev_t          ev
);

  logic              stable_r, stable_nxt;
  logic              pending_r, pending_nxt;
  logic [TIME_W-1:0] last_change_r, last_change_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;

  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] held;
  logic              change_ok;
  logic              press_acc;
  logic              stable_eff;
  logic              pending_eff;
  logic              is_long;

  // debounce check and press timer, both from the stored state
  always_comb begin
    since_change = now_ms - last_change_r;
    change_ok    = (raw_level != stable_r) &&
                   (since_change > {{(TIME_W-CFG_W){1'b0}}, debounce_ms});
    press_acc    = change_ok && raw_level;
    stable_eff   = change_ok ? raw_level : stable_r;
    pending_eff  = pending_r || press_acc;
    held         = press_acc ? '0 : (now_ms - start_r);
    is_long      = held >= {{(TIME_W-CFG_W){1'b0}}, long_press_ms};
  end

  // event decision and next state
  always_comb begin
    ev.valid        = 1'b0;
    ev.kind         = EV_SHORT;
    stable_nxt      = stable_r;
    pending_nxt     = pending_r;
    last_change_nxt = last_change_r;
    start_nxt       = start_r;
    if (accept) begin
      stable_nxt  = stable_eff;
      pending_nxt = pending_eff;
      if (change_ok) begin
        last_change_nxt = now_ms;
      end
      if (press_acc) begin
        start_nxt = now_ms;
      end
      if (pending_eff) begin
        if (!stable_eff) begin
          ev.valid    = 1'b1;
          ev.kind     = is_long ? EV_LONG : EV_SHORT;
          pending_nxt = 1'b0;
        end else if (is_long) begin
          ev.valid    = 1'b1;
          ev.kind     = EV_LONG;
          pending_nxt = 1'b0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r      <= 1'b0;
      pending_r     <= 1'b0;
      last_change_r <= '0;
    end else begin
      stable_r      <= stable_nxt;
      pending_r     <= pending_nxt;
      last_change_r <= last_change_nxt;
    end
  end

  // press start time, only read while a press is pending
  always_ff @(posedge clk) begin
    start_r <= start_nxt;
  end

endmodule

// File: rtl/core/bdpc_merge.sv
// bdpc_merge: collects lane events of one word and sends them out in button order
// depends on bdpc_pkg
module bdpc_merge
  import bdpc_pkg::*;
#(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  lane_ev_t             lane_ev [NUM_BUTTONS],
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [BTN_IDX_W-1:0] out_idx,
  output logic                 out_last
);

  localparam int CNT_W = $clog2(MAX_EVENTS + 1);

  logic [NUM_BUTTONS-1:0] pend_r, pend_nxt;
  logic [NUM_BUTTONS-1:0] kind_r, kind_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic [BTN_IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [NUM_BUTTONS-1:0] cap_mask;
  logic [NUM_BUTTONS-1:0] cap_kind;
  logic [CNT_W-1:0]       cap_cnt;
  logic [NUM_BUTTONS-1:0] sel;
  logic [NUM_BUTTONS-1:0] rest;
  logic                   sel_kind;
  logic [BTN_IDX_W-1:0]   sel_idx;
  logic                   pop;

  // keep the first MAX_EVENTS events of the word
  always_comb begin
    cap_mask = '0;
    cap_kind = '0;
    cap_cnt  = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      cap_kind[i] = lane_ev[i].kind;
      if (lane_ev[i].valid && (cap_cnt < CNT_W'(MAX_EVENTS))) begin
        cap_mask[i] = 1'b1;
        cap_cnt     = cap_cnt + 1'b1;
      end
    end
  end

  // lowest pending button goes next
  always_comb begin
    sel      = pend_r & (~pend_r + 1'b1);
    rest     = pend_r & ~sel;
    sel_kind = |(sel & kind_r);
    sel_idx  = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (sel[i]) begin
        sel_idx = BTN_IDX_W'(i);
      end
    end
    pop      = (|pend_r) && (!out_valid_r || out_ready);
    in_ready = rst_n && ((pend_r == '0) || (pop && (rest == '0)));
  end

  // pending set and output register
  always_comb begin
    pend_nxt      = pend_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    if (pop) begin
      pend_nxt = rest;
    end
    if (accept) begin
      pend_nxt = cap_mask;
      kind_nxt = cap_kind;
    end
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = sel_kind;
      out_idx_nxt   = sel_idx;
      out_last_nxt  = (rest == '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_idx   = out_idx_r;
  assign out_last  = out_last_r;

endmodule

// File: rtl/core/button_debounce_press_classifier_top.sv
// button_debounce_press_classifier_top: debounces buttons and reports short/long presses
// depends on bdpc_pkg, bdpc_lane, bdpc_merge
//
//   channel | direction | handshake          | payload
//   in_     | slave     | in_tvalid/tready   | tdata: now_ms, button_levels
//   out_    | master    | out_tvalid/tready  | tdata: button_index; tuser: kind; tlast
//   cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data
//
// all lanes update in the cycle a sample word is accepted; the events it causes
// drain one per cycle from the merge stage into the output register while the
// output is not stalled. a word causes up to four events; with none the input
// stays ready, else the next word is taken in the cycle its last event moves out.
// reset is synchronous; it clears button state and restores register defaults.
// a stalled output holds its word and blocks new samples once events queue.
module button_debounce_press_classifier_top
  import bdpc_pkg::*;
#(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] now_ms, [35:32] button_levels
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [1:0] button_index
  output logic                  out_tuser,  // [0] event_kind
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic [CFG_W-1:0]     debounce_r, debounce_nxt;
  logic [CFG_W-1:0]     long_press_r, long_press_nxt;
  logic                 in_accept;
  logic [TIME_W-1:0]    now_ms;
  logic [LEVEL_W-1:0]   levels;
  lane_ev_t             lane_ev [NUM_BUTTONS];
  logic                 any_ev;
  logic [BTN_IDX_W-1:0] out_idx;

  // configuration registers
  assign cfg_ready = rst_n;

  always_comb begin
    debounce_nxt   = debounce_r;
    long_press_nxt = long_press_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_nxt   = cfg_data;
        CFG_LONG_PRESS: long_press_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else begin
      debounce_r   <= debounce_nxt;
      long_press_r <= long_press_nxt;
    end
  end

  // input word
  assign in_accept = in_tvalid && in_tready;
  assign now_ms    = in_tdata[TIME_W-1:0];
  assign levels    = in_tdata[TIME_W +: LEVEL_W];

  // one lane per button; buttons past the level field read as released
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    logic raw;
    if (g < LEVEL_W) begin : g_in
      assign raw = levels[g];
    end else begin : g_off
      assign raw = 1'b0;
    end

    bdpc_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .accept        (in_accept),
      .now_ms        (now_ms),
      .raw_level     (raw),
      .debounce_ms   (debounce_r),
      .long_press_ms (long_press_r),
      .ev            (lane_ev[g])
    );
  end

  // event merge and output register
  bdpc_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .lane_ev   (lane_ev),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_idx   (out_idx),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W-BTN_IDX_W){1'b0}}, out_idx};

  // any event in the accepted word
  always_comb begin
    any_ev = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      any_ev = any_ev | lane_ev[i].valid;
    end
  end

  // output is valid once the events of a taken word pass the pending set into the output register
  a_event_reaches_out : assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_accept && any_ev) |-> ##2 out_tvalid
  ) else $error("events of an accepted word did not reach the output");

  // queued events with a stalled output must hold off the next sample
  a_stall_blocks_input : assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_accept && any_ev) |=> (!(out_tvalid && !out_tready) || !in_tready)
  ) else $error("new sample taken while events queue behind a stalled output");

  // lanes report nothing unless a word is taken
  a_no_event_idle : assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_accept |-> !any_ev
  ) else $error("lane event without an accepted word");

endmodule
